>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bdve_pkg.sv
// ---------------------------------------------------------------------------
// bdve_pkg
// Types and constants of the block delta variable-byte encoder.
// ---------------------------------------------------------------------------
package bdve_pkg;

   // Widest code of a 32-bit gap at seven bits a byte.
   localparam int MAX_CODE_BYTES = 5;
   // Width of a block byte count for the largest supported block of 256 values.
   localparam int COUNT_W = 11;

   typedef struct packed {
      logic [31:0] value;
      logic        list_end;
   } req_type;

   typedef enum logic [1:0] {
      KIND_CODE  = 2'd0,
      KIND_COUNT = 2'd1,
      KIND_LAST  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
      logic        run_end;
   } rsp_type;

   // One classified value as handed from the front end to the back end.
   typedef struct packed {
      logic [31:0]        gap;
      logic [2:0]         nbytes;
      logic               close;
      logic               emit_last;
      logic [COUNT_W-1:0] count;
      logic [31:0]        last_value;
   } job_type;

   // Number of variable-byte code bytes that a gap needs.
   function automatic logic [2:0] code_length(logic [31:0] gap);
      logic [2:0] len;
      if (gap[31:7] == '0) begin
         len = 3'd1;
      end else if (gap[31:14] == '0) begin
         len = 3'd2;
      end else if (gap[31:21] == '0) begin
         len = 3'd3;
      end else if (gap[31:28] == '0) begin
         len = 3'd4;
      end else begin
         len = 3'd5;
      end
      return len;
   endfunction

endpackage

>>> hw/rtl/bdve_front.sv
// ---------------------------------------------------------------------------
// bdve_front
// Accepts input beats, forms the gap and its code length, and tracks blocks.
// ---------------------------------------------------------------------------
module bdve_front #(
   parameter int BLOCK_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdve_pkg::req_type req_item,
   input  logic              queue_full,
   output logic              push,
   output bdve_pkg::job_type job
);
   import bdve_pkg::*;

   localparam int VCNT_W = $clog2(BLOCK_SIZE + 1);
   localparam int BCNT_W = $clog2(MAX_CODE_BYTES * BLOCK_SIZE + 1);

   logic              carry_mode_ff;
   logic [31:0]       prev_ff, prev_in;
   logic [VCNT_W-1:0] vib_ff, vib_in;
   logic [BCNT_W-1:0] bib_ff, bib_in;

   logic [31:0]       base;
   logic [31:0]       gap;
   logic [2:0]        nbytes;
   logic [BCNT_W-1:0] byte_total;
   logic              close;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      // In reset mode the base is zeroed when a block opens.
      base       = (vib_ff == '0 && !carry_mode_ff) ? 32'd0 : prev_ff;
      gap        = req_item.value - base;
      nbytes     = code_length(gap);
      byte_total = bib_ff + BCNT_W'(nbytes);
      close      = req_item.list_end || (vib_ff == VCNT_W'(BLOCK_SIZE - 1));

      job.gap        = gap;
      job.nbytes     = nbytes;
      job.close      = close;
      job.emit_last  = carry_mode_ff;
      job.count      = COUNT_W'(byte_total);
      job.last_value = req_item.value;

      prev_in = prev_ff;
      vib_in  = vib_ff;
      bib_in  = bib_ff;
      if (push) begin
         prev_in = req_item.list_end ? 32'd0 : req_item.value;
         vib_in  = close ? '0 : vib_ff + VCNT_W'(1);
         bib_in  = close ? '0 : byte_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_mode_ff <= 1'b1;
         prev_ff       <= '0;
         vib_ff        <= '0;
         bib_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            carry_mode_ff <= csr_write_data;
         end
         prev_ff <= prev_in;
         vib_ff  <= vib_in;
         bib_ff  <= bib_in;
      end
   end

endmodule

>>> hw/rtl/bdve_queue.sv
// ---------------------------------------------------------------------------
// bdve_queue
// Two-entry job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module bdve_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bdve_pkg::job_type push_job,
   output logic              full,
   output logic              head_valid,
   output bdve_pkg::job_type head_job,
   input  logic              pop
);
   import bdve_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/bdve_back.sv
// ---------------------------------------------------------------------------
// bdve_back
// Turns one job into its result beats through a registered output stage.
// ---------------------------------------------------------------------------
module bdve_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  bdve_pkg::job_type job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdve_pkg::rsp_type rsp_item
);
   import bdve_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] step_ff, step_in;

   logic [2:0] total;
   logic       last_beat;
   logic       load;
   logic [6:0] chunk;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      total     = job.nbytes + 3'(job.close) + 3'(job.close && job.emit_last);
      last_beat = (step_ff == total - 3'd1);
      load      = job_valid && (!rsp_valid_ff || !rsp_stall);
      pop       = load && last_beat;

      case (step_ff)
         3'd0:    chunk = job.gap[6:0];
         3'd1:    chunk = job.gap[13:7];
         3'd2:    chunk = job.gap[20:14];
         3'd3:    chunk = job.gap[27:21];
         default: chunk = {3'b000, job.gap[31:28]};
      endcase

      rsp_in.run_end = last_beat;
      if (step_ff < job.nbytes) begin
         // Continuation flag on every code byte but the final one.
         rsp_in.kind = KIND_CODE;
         rsp_in.data = {24'd0, (step_ff != job.nbytes - 3'd1), chunk};
      end else if (step_ff == job.nbytes) begin
         rsp_in.kind = KIND_COUNT;
         rsp_in.data = 32'(job.count);
      end else begin
         rsp_in.kind = KIND_LAST;
         rsp_in.data = job.last_value;
      end

      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = job_valid;
      end
      step_in = step_ff;
      if (load) begin
         step_in = last_beat ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

endmodule

>>> hw/rtl/block_delta_varint_encoder_unit.sv
// ---------------------------------------------------------------------------
// block_delta_varint_encoder_unit
// Block delta variable-byte encoder: gaps of a value list as byte codes.
// ---------------------------------------------------------------------------
// Each input beat carries one 32-bit value of a list. The unit replaces it by
// its gap from the previous value (zero at a list start and, outside carry
// mode, a block start), modulo 2^32, and sends that gap as one to five code
// bytes, seven bits a byte, least significant group first, with bit 7 set on
// every byte but the final one. Values are grouped in blocks of BLOCK_SIZE;
// a block closes after BLOCK_SIZE values or at the end of a list, and then
// the block's total number of code bytes follows as one beat, and in carry
// mode the block's last value as another. The final result beat of each input
// beat has run_end set. The carry_mode register (reset value 1) is written
// through csr_write_enable and csr_write_data; the user must write it only
// while the unit is idle, which the unit does not check. Throughput is one
// result beat per clock cycle while the output is not stalled, set by the
// back end's single registered output stage; a value yields one to five code
// bytes, plus one or two beats when it closes a block. The front end takes a
// new input beat in every cycle in which the two-entry job queue has room, so
// input and output stall independently. A value's first result beat is
// offered only after it has passed a queue entry and the output register.
// ---------------------------------------------------------------------------
module block_delta_varint_encoder_unit #(
   parameter int BLOCK_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdve_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdve_pkg::rsp_type rsp_item
);
   import bdve_pkg::*;

   // Front end to queue.
   logic    push;
   logic    queue_full;
   job_type new_job;

   // Queue to back end.
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // The front end forms the gap, its code length and the block bookkeeping,
   // all in the cycle in which the value is accepted.
   bdve_front #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .queue_full       (queue_full),
      .push             (push),
      .job              (new_job)
   );

   // Two jobs of slack let the front end run on while a result beat stalls.
   bdve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (new_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // The back end walks through the beats of the head job, one per cycle
   // unless the output stalls, and releases the job with its final beat.
   bdve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hw/rtl/bdve_checker.sv
// ---------------------------------------------------------------------------
// bdve_checker
// Port-level checks of the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdve_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bdve_pkg::rsp_type rsp_item
);
   import bdve_pkg::*;

   // A stalled result beat stays offered and unchanged.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled result beat changed")

   // Nothing is offered in the cycle after reset.
   `ASSERT_CLK(a_rsp_reset, clock, reset |=> !rsp_valid, "result beat offered after reset")

   // A code byte with its continuation flag set is never the final beat.
   `ASSERT_CLK_RST(a_code_cont, clock, reset, rsp_valid && rsp_item.kind == KIND_CODE && rsp_item.data[7] |-> !rsp_item.run_end, "continued code byte ends a run")

   // Code bytes carry nothing above bit 7.
   `ASSERT_CLK_RST(a_code_width, clock, reset, rsp_valid && rsp_item.kind == KIND_CODE |-> rsp_item.data[31:8] == 24'd0, "code byte wider than eight bits")

   // The block last value is always the final beat of its run.
   `ASSERT_CLK_RST(a_last_ends, clock, reset, rsp_valid && rsp_item.kind == KIND_LAST |-> rsp_item.run_end, "last value beat does not end its run")

endmodule

bind block_delta_varint_encoder_unit bdve_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
